[rtl/eps_pkg.sv]
package eps_pkg;

    // Window length in ticks and hard limit on the drive magnitude
    localparam int WINDOW_TICKS = 10;
    localparam int DRIVE_MAX    = 10000;

    // Field and state widths
    localparam int CNT_W    = 16;
    localparam int TICK_W   = 4;
    localparam int SUM_W    = 20;
    localparam int ERR_W    = 21;
    localparam int DER_W    = 22;
    localparam int DRV_W    = 15;
    localparam int DUTY_W   = 14;
    localparam int TGT_W    = 14;
    localparam int GAIN_W   = 16;
    localparam int BAND_W   = 16;
    localparam int CLAMP_W  = 20;
    localparam int SLEW_W   = 14;
    localparam int PROD_W   = GAIN_W + DER_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int Q_W      = 16;
    localparam int Q_MAX    = 32767;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // Rate limit arithmetic width and the hard drive limit at that width
    localparam int STEP_W   = Q_W + 1;
    localparam logic signed [STEP_W-1:0] DRV_LIM = STEP_W'(DRIVE_MAX);

    // Register map, word index
    typedef enum logic [2:0] {
        REG_TARGET,
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_GAIN_FF,
        REG_INTEG_BAND,
        REG_INTEG_CLAMP,
        REG_SLEW_LIMIT
    } reg_idx_t;

    typedef struct packed {
        logic signed [TGT_W-1:0]  setpoint;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic signed [GAIN_W-1:0] gain_ff;
        logic [BAND_W-1:0]        integ_band;
        logic [CLAMP_W-1:0]       integ_clamp;
        logic [SLEW_W-1:0]        slew_limit;
    } cfg_t;

endpackage

[rtl/eps_cfg_regs.sv]
module eps_cfg_regs
    import eps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Capture register writes in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_TARGET:      cfg_reg.setpoint      <= pwdata[TGT_W-1:0];
                REG_GAIN_P:      cfg_reg.gain_p        <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:      cfg_reg.gain_i        <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:      cfg_reg.gain_d        <= pwdata[GAIN_W-1:0];
                REG_GAIN_FF:     cfg_reg.gain_ff       <= pwdata[GAIN_W-1:0];
                REG_INTEG_BAND:  cfg_reg.integ_band    <= pwdata[BAND_W-1:0];
                REG_INTEG_CLAMP: cfg_reg.integ_clamp   <= pwdata[CLAMP_W-1:0];
                REG_SLEW_LIMIT:  cfg_reg.slew_limit    <= pwdata[SLEW_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the raw register bits
    always_comb begin
        case (idx)
            REG_TARGET:      prdata = {{(APB_DW-TGT_W){1'b0}}, cfg_reg.setpoint};
            REG_GAIN_P:      prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg_reg.gain_p};
            REG_GAIN_I:      prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg_reg.gain_i};
            REG_GAIN_D:      prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg_reg.gain_d};
            REG_GAIN_FF:     prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg_reg.gain_ff};
            REG_INTEG_BAND:  prdata = {{(APB_DW-BAND_W){1'b0}}, cfg_reg.integ_band};
            REG_INTEG_CLAMP: prdata = {{(APB_DW-CLAMP_W){1'b0}}, cfg_reg.integ_clamp};
            REG_SLEW_LIMIT:  prdata = {{(APB_DW-SLEW_W){1'b0}}, cfg_reg.slew_limit};
            default:         prdata = '0;
        endcase
    end

endmodule

[rtl/encoder_pid_speed_loop.sv]
// Encoder speed loop with PID and feedforward. Every accepted encoder sample gives exactly one
// result, which appears on the result channel from the result register of the last stage;
// a five-stage pipeline (window count, integral, products, Q8.8 scaling, rate/hard limit)
// takes a new sample in every cycle, and each stage only holds while the stage after it is
// full and stalled. Every tenth tick closes a window and runs the control update; the integral
// and last error live in the second stage and the drive in the last stage, so back-to-back
// window ends see each other's results. Write the configuration registers only while no
// sample is in flight.
module encoder_pid_speed_loop
    import eps_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // sample channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CNT_W-1:0]         s_encoder_count,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DUTY_W-1:0]        m_duty,
    output logic                     m_forward,
    output logic signed [CNT_W-1:0]  m_tick_delta,
    output logic signed [SUM_W-1:0]  m_window_pulses,
    output logic                     m_updated,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    cfg_t cfg;

    eps_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic ld1, ld2, ld3, ld4, ld5, take;

    assign rdy5 = !v5_reg || m_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_ready = rdy1;

    assign ld1  = s_valid && rdy1;
    assign ld2  = v1_reg && rdy2;
    assign ld3  = v2_reg && rdy3;
    assign ld4  = v3_reg && rdy4;
    assign ld5  = v4_reg && rdy5;
    assign take = v5_reg && m_ready;

    // Advance the valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= ld1 ? 1'b1 : (ld2 ? 1'b0 : v1_reg);
            v2_reg <= ld2 ? 1'b1 : (ld3 ? 1'b0 : v2_reg);
            v3_reg <= ld3 ? 1'b1 : (ld4 ? 1'b0 : v3_reg);
            v4_reg <= ld4 ? 1'b1 : (ld5 ? 1'b0 : v4_reg);
            v5_reg <= ld5 ? 1'b1 : (take ? 1'b0 : v5_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: delta and window accumulation
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]        baseline_reg;
    logic                    first_reg;
    logic [TICK_W-1:0]       tick_reg;
    logic signed [SUM_W-1:0] window_sum_reg;
    logic signed [SUM_W-1:0] last_window_reg;

    logic signed [CNT_W-1:0] delta;
    logic [TICK_W-1:0]       tick_inc;
    logic                    win_end;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] last_window_next;

    assign delta    = first_reg ? '0 : signed'(s_encoder_count - baseline_reg);
    assign tick_inc = tick_reg + TICK_W'(1);
    assign win_end  = tick_inc >= TICK_W'(WINDOW_TICKS);
    assign sum_next = window_sum_reg + SUM_W'(delta);
    assign last_window_next = win_end ? sum_next : last_window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg    <= '0;
            first_reg       <= 1'b1;
            tick_reg        <= '0;
            window_sum_reg  <= '0;
            last_window_reg <= '0;
        end else if (ld1) begin
            baseline_reg    <= s_encoder_count;
            first_reg       <= 1'b0;
            tick_reg        <= win_end ? '0 : tick_inc;
            window_sum_reg  <= win_end ? '0 : sum_next;
            last_window_reg <= last_window_next;
        end
    end

    logic signed [CNT_W-1:0] s1_delta_reg;
    logic signed [SUM_W-1:0] s1_wp_reg;
    logic                    s1_upd_reg;
    logic signed [TGT_W-1:0] s1_target_reg;

    always_ff @(posedge aclk) begin
        if (ld1) begin
            s1_delta_reg  <= delta;
            s1_wp_reg     <= last_window_next;
            s1_upd_reg    <= win_end;
            s1_target_reg <= cfg.setpoint;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: error, banded and clamped integral, difference
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0] error_sum_reg;
    logic signed [ERR_W-1:0] prev_error_reg;

    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]        abs_err;
    logic                    in_band;
    logic signed [DER_W-1:0] isum;
    logic signed [DER_W-1:0] ilim;
    logic signed [DER_W-1:0] isum_clamped;
    logic signed [ERR_W-1:0] es_new;
    logic signed [DER_W-1:0] deriv;
    logic                    s1_zero;

    assign s1_zero = s1_target_reg == '0;
    assign err     = ERR_W'(s1_target_reg) - ERR_W'(s1_wp_reg);
    assign abs_err = err[ERR_W-1] ? unsigned'(-err) : unsigned'(err);
    assign in_band = abs_err < ERR_W'(cfg.integ_band);
    assign isum    = DER_W'(error_sum_reg) + DER_W'(err);
    assign ilim    = signed'({{(DER_W-CLAMP_W){1'b0}}, cfg.integ_clamp});
    assign deriv   = DER_W'(err) - DER_W'(prev_error_reg);

    // Clamp the accumulated error symmetrically
    always_comb begin
        if (isum > ilim) begin
            isum_clamped = ilim;
        end else if (isum < -ilim) begin
            isum_clamped = -ilim;
        end else begin
            isum_clamped = isum;
        end
        es_new = in_band ? isum_clamped[ERR_W-1:0] : error_sum_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
        end else if (ld2 && s1_upd_reg) begin
            error_sum_reg  <= s1_zero ? '0 : es_new;
            prev_error_reg <= s1_zero ? '0 : err;
        end
    end

    logic signed [ERR_W-1:0] s2_err_reg;
    logic signed [ERR_W-1:0] s2_es_reg;
    logic signed [DER_W-1:0] s2_deriv_reg;
    logic signed [TGT_W-1:0] s2_target_reg;
    logic                    s2_zero_reg;
    logic                    s2_upd_reg;
    logic signed [CNT_W-1:0] s2_delta_reg;
    logic signed [SUM_W-1:0] s2_wp_reg;

    always_ff @(posedge aclk) begin
        if (ld2) begin
            s2_err_reg    <= err;
            s2_es_reg     <= es_new;
            s2_deriv_reg  <= deriv;
            s2_target_reg <= s1_target_reg;
            s2_zero_reg   <= s1_zero;
            s2_upd_reg    <= s1_upd_reg;
            s2_delta_reg  <= s1_delta_reg;
            s2_wp_reg     <= s1_wp_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the four gain products, one multiplier each
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] p_ff_reg, p_p_reg, p_i_reg, p_d_reg;
    logic                     s3_zero_reg;
    logic                     s3_upd_reg;
    logic signed [CNT_W-1:0]  s3_delta_reg;
    logic signed [SUM_W-1:0]  s3_wp_reg;

    always_ff @(posedge aclk) begin
        if (ld3) begin
            p_ff_reg     <= PROD_W'(cfg.gain_ff) * PROD_W'(s2_target_reg);
            p_p_reg      <= PROD_W'(cfg.gain_p) * PROD_W'(s2_err_reg);
            p_i_reg      <= PROD_W'(cfg.gain_i) * PROD_W'(s2_es_reg);
            p_d_reg      <= PROD_W'(cfg.gain_d) * PROD_W'(s2_deriv_reg);
            s3_zero_reg  <= s2_zero_reg;
            s3_upd_reg   <= s2_upd_reg;
            s3_delta_reg <= s2_delta_reg;
            s3_wp_reg    <= s2_wp_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sum, drop the Q8.8 fraction toward zero, saturate
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_biased;
    logic signed [ACC_W-1:0] q_full;
    logic signed [Q_W-1:0]   q_sat;

    assign acc = ACC_W'(p_ff_reg) + ACC_W'(p_p_reg) + ACC_W'(p_i_reg) + ACC_W'(p_d_reg);
    assign acc_biased = acc[ACC_W-1] ? acc + ACC_W'(255) : acc;
    assign q_full = acc_biased >>> 8;

    always_comb begin
        if (q_full > ACC_W'(Q_MAX)) begin
            q_sat = Q_W'(Q_MAX);
        end else if (q_full < -ACC_W'(Q_MAX)) begin
            q_sat = -Q_W'(Q_MAX);
        end else begin
            q_sat = q_full[Q_W-1:0];
        end
    end

    logic signed [Q_W-1:0]   s4_q_reg;
    logic                    s4_zero_reg;
    logic                    s4_upd_reg;
    logic signed [CNT_W-1:0] s4_delta_reg;
    logic signed [SUM_W-1:0] s4_wp_reg;

    always_ff @(posedge aclk) begin
        if (ld4) begin
            s4_q_reg     <= q_sat;
            s4_zero_reg  <= s3_zero_reg;
            s4_upd_reg   <= s3_upd_reg;
            s4_delta_reg <= s3_delta_reg;
            s4_wp_reg    <= s3_wp_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: rate limit, hard limit, drive state and result register
    // ------------------------------------------------------------------
    logic signed [DRV_W-1:0]  drive_reg;
    logic signed [STEP_W-1:0] diff;
    logic signed [STEP_W-1:0] slim;
    logic signed [STEP_W-1:0] diff_c;
    logic signed [STEP_W-1:0] drv_sum;
    logic signed [DRV_W-1:0]  drv_lim;
    logic signed [DRV_W-1:0]  drive_next;

    assign diff    = STEP_W'(s4_q_reg) - STEP_W'(drive_reg);
    assign slim    = signed'({{(STEP_W-SLEW_W){1'b0}}, cfg.slew_limit});
    assign drv_sum = STEP_W'(drive_reg) + diff_c;

    // Clamp the drive change to the slew limit
    always_comb begin
        if (diff > slim) begin
            diff_c = slim;
        end else if (diff < -slim) begin
            diff_c = -slim;
        end else begin
            diff_c = diff;
        end
    end

    // Hard limit the drive and pick the new drive state
    always_comb begin
        if (drv_sum > DRV_LIM) begin
            drv_lim = DRV_W'(DRV_LIM);
        end else if (drv_sum < -DRV_LIM) begin
            drv_lim = DRV_W'(-DRV_LIM);
        end else begin
            drv_lim = drv_sum[DRV_W-1:0];
        end
        if (!s4_upd_reg) begin
            drive_next = drive_reg;
        end else if (s4_zero_reg) begin
            drive_next = '0;
        end else begin
            drive_next = drv_lim;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg <= '0;
        end else if (ld5) begin
            drive_reg <= drive_next;
        end
    end

    logic [DUTY_W-1:0]       duty_reg;
    logic                    forward_reg;
    logic signed [CNT_W-1:0] delta_out_reg;
    logic signed [SUM_W-1:0] wp_out_reg;
    logic                    upd_out_reg;
    logic                    zero_out_reg;
    logic [DRV_W-1:0]        drive_mag;

    assign drive_mag = drive_next[DRV_W-1] ? unsigned'(-drive_next) : unsigned'(drive_next);

    always_ff @(posedge aclk) begin
        if (ld5) begin
            duty_reg      <= drive_mag[DUTY_W-1:0];
            forward_reg   <= !drive_next[DRV_W-1];
            delta_out_reg <= s4_delta_reg;
            wp_out_reg    <= s4_wp_reg;
            upd_out_reg   <= s4_upd_reg;
            zero_out_reg  <= s4_zero_reg;
        end
    end

    assign m_valid         = v5_reg;
    assign m_duty          = duty_reg;
    assign m_forward       = forward_reg;
    assign m_tick_delta    = delta_out_reg;
    assign m_window_pulses = wp_out_reg;
    assign m_updated       = upd_out_reg;

`ifndef SYNTH
    // A stop update always leaves the motor idle and pointing forward
    a_stop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_updated && zero_out_reg |-> m_duty == '0 && m_forward)
        else $error("stop update left a non-zero drive");

    // The duty never exceeds the hard limit
    a_duty_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_duty <= DUTY_W'(DRIVE_MAX))
        else $error("duty above hard limit");

    // Back-pressure only appears with every stage full
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v1_reg && v2_reg && v3_reg && v4_reg && v5_reg)
        else $error("input stalled with a free stage");

    // The drive only moves on a control update
    a_drive_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ld5 && !s4_upd_reg |=> $stable(drive_reg))
        else $error("drive changed outside a control update");
`endif

endmodule
